@@ src/wtb_pkg.sv @@
// ----------------------------------------------------------------------------
// wtb_pkg
// Shared types and constants for the wall temperature bisection solver.
// ----------------------------------------------------------------------------
package wtb_pkg;

	localparam int TEMP_BITS    = 20;
	localparam int FLUX_BITS    = 32;
	localparam int RES_BITS     = 32;
	localparam int RELAX_BITS   = 16;
	localparam int TOL_BITS     = 24;
	localparam int ITER_BITS    = 8;
	localparam int CFG_BITS     = 32;
	localparam int CFG_IDX_BITS = 3;
	localparam int MUL_BITS     = 64;
	localparam int PROD_BITS    = 2 * MUL_BITS;

	// fraction shifts of the fixed-point chain
	localparam int T4_SHIFT   = 40;
	localparam int RAD_SHIFT  = 48;
	localparam int RISE_SHIFT = 24;
	localparam int BLEND_SHIFT = 15;

	// sigma * 2^60
	localparam logic [35:0] SIGMA_Q60 = 36'd65370649311;
	localparam logic [RELAX_BITS-1:0] ONE_Q15  = RELAX_BITS'(32768);
	localparam logic [MUL_BITS-1:0]   HALF_Q15 = MUL_BITS'(16384);

	localparam logic [TEMP_BITS-1:0]  RST_INNER_TEMP  = TEMP_BITS'(95488);
	localparam logic [RES_BITS-1:0]   RST_WALL_RES    = RES_BITS'(2684355);
	localparam logic [TEMP_BITS-1:0]  RST_MAX_TEMP    = TEMP_BITS'(768000);
	localparam logic [TEMP_BITS-1:0]  RST_MIN_TEMP    = TEMP_BITS'(95488);
	localparam logic [RELAX_BITS-1:0] RST_RELAX       = RELAX_BITS'(32768);
	localparam logic [TOL_BITS-1:0]   RST_INIT_TOL    = TOL_BITS'(16777);
	localparam logic [TOL_BITS-1:0]   RST_TOL         = TOL_BITS'(168);
	localparam logic [ITER_BITS-1:0]  RST_MAX_ITER    = ITER_BITS'(50);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_INNER_TEMP   = 3'd0,
		CFG_WALL_RES     = 3'd1,
		CFG_MAX_TEMP     = 3'd2,
		CFG_MIN_TEMP     = 3'd3,
		CFG_RELAX        = 3'd4,
		CFG_INIT_TOL     = 3'd5,
		CFG_TOL          = 3'd6,
		CFG_MAX_ITER     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [FLUX_BITS-1:0] incident_flux;
		logic [TEMP_BITS-1:0] old_temp;
	} in_t;

	typedef struct packed {
		logic [TEMP_BITS-1:0] new_temp;
		logic [ITER_BITS-1:0] steps_taken;
		logic                 hit_limit;
	} out_t;

	typedef enum logic [3:0] {
		OP_LOAD    = 4'd0,
		OP_SQ      = 4'd1,
		OP_T4      = 4'd2,
		OP_RAD     = 4'd3,
		OP_RISE    = 4'd4,
		OP_BRACKET = 4'd5,
		OP_TOL0    = 4'd6,
		OP_MID     = 4'd7,
		OP_UPDATE  = 4'd8,
		OP_TOL     = 4'd9,
		OP_B1      = 4'd10,
		OP_B2      = 4'd11,
		OP_OUT     = 4'd12
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   mul_start;
		logic   exec;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic start_ok;
		logic wide;
		logic more;
	} dp_stat_t;

endpackage

@@ src/wtb_mul.sv @@
// ----------------------------------------------------------------------------
// wtb_mul
// Iterative 64x64 multiplier: one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module wtb_mul import wtb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MUL_BITS-1:0]  a,
	input  logic [MUL_BITS-1:0]  b,
	output logic                 done,
	output logic [PROD_BITS-1:0] prod
);

	localparam int DIG = MUL_BITS / 2;

	logic [MUL_BITS-1:0]  a_q, b_q;
	logic [PROD_BITS-1:0] acc_q;
	logic [1:0]           cnt_q;
	logic                 run_q, done_q;
	logic [DIG-1:0]       a_dig, b_dig;
	logic [MUL_BITS-1:0]  pp;
	logic [PROD_BITS-1:0] term;

	always_comb begin
		a_dig = cnt_q[0] ? a_q[MUL_BITS-1:DIG] : a_q[DIG-1:0];
		b_dig = cnt_q[1] ? b_q[MUL_BITS-1:DIG] : b_q[DIG-1:0];
		pp    = MUL_BITS'(a_dig) * MUL_BITS'(b_dig);
		case (cnt_q)
			2'd0:       term = {{MUL_BITS{1'b0}}, pp};
			2'd1, 2'd2: term = {{DIG{1'b0}}, pp, {DIG{1'b0}}};
			2'd3:       term = {pp, {MUL_BITS{1'b0}}};
			default:    term = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd3) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_q + term;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

@@ src/wtb_datapath.sv @@
// ----------------------------------------------------------------------------
// wtb_datapath
// Configuration registers, bracket and trial registers, shared multiplier.
// ----------------------------------------------------------------------------
module wtb_datapath import wtb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	input  in_t                     in_data,
	input  dp_cmd_t                 cmd,
	output dp_stat_t                stat,
	output out_t                    out_data
);

	logic [TEMP_BITS-1:0]  inner_q, max_q, min_q;
	logic [RES_BITS-1:0]   res_q;
	logic [RELAX_BITS-1:0] relax_q;
	logic [TOL_BITS-1:0]   itol_q, tol_q;
	logic [ITER_BITS-1:0]  max_iter_q;

	logic [FLUX_BITS-1:0]  q_q, net_q;
	logic [TEMP_BITS-1:0]  old_q, tw0_q, tw1_q, tmax_q, tmin_q, blend_q;
	logic [MUL_BITS-1:0]   sq_q, t4_q, p_q;
	logic [ITER_BITS-1:0]  steps_q;
	logic                  wide_q, start_q;
	out_t                  out_q;

	logic [MUL_BITS-1:0]   mul_a, mul_b;
	logic                  mul_done;
	logic [PROD_BITS-1:0]  prod;

	logic [TEMP_BITS-1:0]  diff0, diffb, num, rise, tw1_next, mid;
	logic [TEMP_BITS:0]    sum_rise, sum_mid;
	logic [PROD_BITS-1:0]  num_sh;
	logic                  above;
	logic [MUL_BITS-1:0]   t4_next;
	logic [FLUX_BITS-1:0]  rad, net_next;
	logic [RELAX_BITS-1:0] relax_sat;
	logic [MUL_BITS-1:0]   blend_sum;
	cfg_idx_t              cfg_sel;

	assign cfg_sel = cfg_idx_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q    <= RST_INNER_TEMP;
			res_q      <= RST_WALL_RES;
			max_q      <= RST_MAX_TEMP;
			min_q      <= RST_MIN_TEMP;
			relax_q    <= RST_RELAX;
			itol_q     <= RST_INIT_TOL;
			tol_q      <= RST_TOL;
			max_iter_q <= RST_MAX_ITER;
		end else if (cfg_we) begin
			case (cfg_sel)
				CFG_INNER_TEMP: inner_q    <= cfg_data[TEMP_BITS-1:0];
				CFG_WALL_RES:   res_q      <= cfg_data[RES_BITS-1:0];
				CFG_MAX_TEMP:   max_q      <= cfg_data[TEMP_BITS-1:0];
				CFG_MIN_TEMP:   min_q      <= cfg_data[TEMP_BITS-1:0];
				CFG_RELAX:      relax_q    <= cfg_data[RELAX_BITS-1:0];
				CFG_INIT_TOL:   itol_q     <= cfg_data[TOL_BITS-1:0];
				CFG_TOL:        tol_q      <= cfg_data[TOL_BITS-1:0];
				CFG_MAX_ITER:   max_iter_q <= cfg_data[ITER_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign relax_sat = (relax_q > ONE_Q15) ? ONE_Q15 : relax_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQ: begin
				mul_a = MUL_BITS'(tw0_q);
				mul_b = MUL_BITS'(tw0_q);
			end
			OP_T4: begin
				mul_a = sq_q;
				mul_b = sq_q;
			end
			OP_RAD: begin
				mul_a = t4_q;
				mul_b = MUL_BITS'(SIGMA_Q60);
			end
			OP_RISE: begin
				mul_a = MUL_BITS'(net_q);
				mul_b = MUL_BITS'(res_q);
			end
			OP_TOL0: begin
				mul_a = MUL_BITS'(tw1_q);
				mul_b = MUL_BITS'(itol_q);
			end
			OP_TOL: begin
				mul_a = MUL_BITS'(tw0_q);
				mul_b = MUL_BITS'(tol_q);
			end
			OP_B1: begin
				mul_a = MUL_BITS'(old_q);
				mul_b = MUL_BITS'(ONE_Q15 - relax_sat);
			end
			OP_B2: begin
				mul_a = MUL_BITS'(tw0_q);
				mul_b = MUL_BITS'(relax_sat);
			end
			default: ;
		endcase
	end

	wtb_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	always_comb begin
		diff0 = (tw0_q > tw1_q) ? tw0_q - tw1_q : tw1_q - tw0_q;
		diffb = (tmax_q > tmin_q) ? tmax_q - tmin_q : tmin_q - tmax_q;
		num   = (cmd.op == OP_TOL0) ? diff0 : diffb;
		// relative error test by cross multiplication
		num_sh = PROD_BITS'({num, {TOL_BITS{1'b0}}});
		above  = num_sh > prod;

		t4_next = (|prod[PROD_BITS-1:MUL_BITS+T4_SHIFT]) ? {MUL_BITS{1'b1}}
			: prod[MUL_BITS+T4_SHIFT-1:T4_SHIFT];
		rad = (|prod[PROD_BITS-1:FLUX_BITS+RAD_SHIFT]) ? {FLUX_BITS{1'b1}}
			: prod[FLUX_BITS+RAD_SHIFT-1:RAD_SHIFT];
		net_next = (q_q > rad) ? q_q - rad : '0;
		rise = (|prod[PROD_BITS-1:TEMP_BITS+RISE_SHIFT]) ? {TEMP_BITS{1'b1}}
			: prod[TEMP_BITS+RISE_SHIFT-1:RISE_SHIFT];
		sum_rise = {1'b0, inner_q} + {1'b0, rise};
		tw1_next = sum_rise[TEMP_BITS] ? {TEMP_BITS{1'b1}} : sum_rise[TEMP_BITS-1:0];

		sum_mid = {1'b0, tmax_q} + {1'b0, tmin_q};
		mid     = sum_mid[TEMP_BITS:1];

		blend_sum = p_q + prod[MUL_BITS-1:0] + HALF_Q15;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			wide_q  <= 1'b0;
			start_q <= 1'b0;
		end else if (cmd.exec) begin
			case (cmd.op)
				OP_LOAD: begin
					steps_q <= '0;
					wide_q  <= 1'b1;
					start_q <= 1'b0;
				end
				OP_TOL0: start_q <= above;
				OP_TOL: begin
					wide_q  <= above;
					steps_q <= steps_q + ITER_BITS'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			case (cmd.op)
				OP_LOAD: begin
					q_q   <= in_data.incident_flux;
					old_q <= in_data.old_temp;
					tw0_q <= in_data.old_temp;
				end
				OP_SQ:   sq_q  <= prod[MUL_BITS-1:0];
				OP_T4:   t4_q  <= t4_next;
				OP_RAD:  net_q <= net_next;
				OP_RISE: tw1_q <= tw1_next;
				OP_BRACKET: begin
					if (tw1_q < tw0_q) begin
						tmax_q <= (tw0_q > max_q) ? max_q : tw0_q;
						tmin_q <= (tw1_q < min_q) ? min_q : tw1_q;
					end else begin
						tmax_q <= (tw1_q > max_q) ? max_q : tw1_q;
						tmin_q <= (tw0_q < min_q) ? min_q : tw0_q;
					end
				end
				OP_MID: tw0_q <= mid;
				OP_UPDATE: begin
					if (tw1_q < tw0_q) begin
						tmax_q <= tw0_q;
					end else begin
						tmin_q <= tw0_q;
					end
				end
				OP_B1: p_q     <= prod[MUL_BITS-1:0];
				OP_B2: blend_q <= blend_sum[TEMP_BITS+BLEND_SHIFT-1:BLEND_SHIFT];
				OP_OUT: begin
					out_q.new_temp    <= blend_q;
					out_q.steps_taken <= steps_q;
					out_q.hit_limit   <= start_q & wide_q;
				end
				default: ;
			endcase
		end
	end

	assign stat.mul_done = mul_done;
	assign stat.start_ok = start_q;
	assign stat.wide     = wide_q;
	assign stat.more     = steps_q < max_iter_q;
	assign out_data      = out_q;

endmodule

@@ src/wtb_ctrl.sv @@
// ----------------------------------------------------------------------------
// wtb_ctrl
// Sequencer: trial evaluation, bracketing, bisection loop, blend, handshakes.
// ----------------------------------------------------------------------------
module wtb_ctrl import wtb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [13:0] {
		S_IDLE    = 14'b00000000000001,
		S_SQ      = 14'b00000000000010,
		S_T4      = 14'b00000000000100,
		S_RAD     = 14'b00000000001000,
		S_RISE    = 14'b00000000010000,
		S_BRACKET = 14'b00000000100000,
		S_TOL0    = 14'b00000001000000,
		S_LOOP    = 14'b00000010000000,
		S_MID     = 14'b00000100000000,
		S_UPDATE  = 14'b00001000000000,
		S_TOL     = 14'b00010000000000,
		S_B1      = 14'b00100000000000,
		S_B2      = 14'b01000000000000,
		S_OUT     = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic   issued_q, issued_d;
	logic   first_q, first_d;
	logic   out_valid_q, out_valid_d;
	logic   is_mul;
	state_t mul_next;

	always_comb begin
		cmd         = '{op: OP_LOAD, mul_start: 1'b0, exec: 1'b0};
		state_d     = state_q;
		first_d     = first_q;
		is_mul      = 1'b0;
		mul_next    = state_q;
		out_valid_d = out_valid_q & out_stall;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.exec = 1'b1;
					first_d  = 1'b1;
					state_d  = S_SQ;
				end
			end
			S_SQ: begin
				cmd.op = OP_SQ; is_mul = 1'b1; mul_next = S_T4;
			end
			S_T4: begin
				cmd.op = OP_T4; is_mul = 1'b1; mul_next = S_RAD;
			end
			S_RAD: begin
				cmd.op = OP_RAD; is_mul = 1'b1; mul_next = S_RISE;
			end
			S_RISE: begin
				cmd.op = OP_RISE; is_mul = 1'b1;
				mul_next = first_q ? S_BRACKET : S_UPDATE;
			end
			S_BRACKET: begin
				cmd.op   = OP_BRACKET;
				cmd.exec = 1'b1;
				state_d  = S_TOL0;
			end
			S_TOL0: begin
				cmd.op = OP_TOL0; is_mul = 1'b1; mul_next = S_LOOP;
			end
			S_LOOP: begin
				if (stat.start_ok && stat.wide && stat.more) begin
					first_d = 1'b0;
					state_d = S_MID;
				end else begin
					state_d = S_B1;
				end
			end
			S_MID: begin
				cmd.op   = OP_MID;
				cmd.exec = 1'b1;
				state_d  = S_SQ;
			end
			S_UPDATE: begin
				cmd.op   = OP_UPDATE;
				cmd.exec = 1'b1;
				state_d  = S_TOL;
			end
			S_TOL: begin
				cmd.op = OP_TOL; is_mul = 1'b1; mul_next = S_LOOP;
			end
			S_B1: begin
				cmd.op = OP_B1; is_mul = 1'b1; mul_next = S_B2;
			end
			S_B2: begin
				cmd.op = OP_B2; is_mul = 1'b1; mul_next = S_OUT;
			end
			S_OUT: begin
				cmd.op = OP_OUT;
				// previous result gone or leaving this cycle
				if (!out_valid_q || !out_stall) begin
					cmd.exec    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		issued_d = issued_q;
		if (is_mul) begin
			cmd.mul_start = !issued_q;
			issued_d      = 1'b1;
			if (stat.mul_done) begin
				cmd.exec = 1'b1;
				issued_d = 1'b0;
				state_d  = mul_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			issued_q    <= issued_d;
			first_q     <= first_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ src/wall_temperature_bisection.sv @@
// ----------------------------------------------------------------------------
// wall_temperature_bisection
// Wall cell temperature solve: net flux, bracket, bisection, relaxation.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries incident flux and old
// temperature; output channel out_valid/out_stall/out_data returns the
// relaxed temperature, step count and limit flag. One result per transaction.
// Configuration: cfg_we, cfg_index, cfg_data write one register per cycle;
// the user writes only while the block is idle; the block does not check it.
// One item at a time. Every product goes through one iterative multiplier
// (one 32x32 partial product per cycle). A trial temperature takes four
// multiplies and each tolerance test one.
// Reset clears the controller and the output valid and loads the register
// defaults. When the receiver stalls, the result register holds; a new input
// transaction is still taken and computed, and its result waits inside until
// the output register frees up.
// ----------------------------------------------------------------------------
module wall_temperature_bisection import wtb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  in_t                     in_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output out_t                    out_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	wtb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	wtb_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule
